// File: design/json_string_escaper_utf8_check_unit_defines.svh
`ifndef JSON_STRING_ESCAPER_UTF8_CHECK_UNIT_DEFINES_SVH
`define JSON_STRING_ESCAPER_UTF8_CHECK_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define JSEU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define JSEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/jseu_pkg.sv
package jseu_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int PIECE_MAX   = 6;
  localparam int LIMIT_W     = 13;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] E0_MIN    = 8'ha0;
  localparam logic [7:0] ED_LEAD   = 8'hed;
  localparam logic [7:0] ED_LIM    = 8'ha0;
  localparam logic [7:0] F0_MIN    = 8'h90;
  localparam logic [7:0] F4_MAX    = 8'h8f;

  typedef struct packed {
    logic [PIECE_MAX-1:0][7:0] bytes;
    logic [2:0]                len;
    logic                      last;
    logic                      rej;
  } jseu_piece_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jseu_qstat_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) r = 8'h30 + {4'd0, v};
    else r = 8'h57 + {4'd0, v};
    return r;
  endfunction

  function automatic logic [7:0] short_escape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h22: r = 8'h22;
      8'h5c: r = 8'h5c;
      8'h08: r = 8'h62;
      8'h0c: r = 8'h66;
      8'h0a: r = 8'h6e;
      8'h0d: r = 8'h72;
      8'h09: r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic second_byte_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    if (lead == LEAD3_LO && b < E0_MIN) ok = 1'b0;
    if (lead == ED_LEAD && b >= ED_LIM) ok = 1'b0;
    if (lead == LEAD4_LO && b < F0_MIN) ok = 1'b0;
    if (lead == LEAD4_HI && b > F4_MAX) ok = 1'b0;
    return ok;
  endfunction

endpackage

// File: design/jseu_front.sv
`include "json_string_escaper_utf8_check_unit_defines.svh"
module jseu_front #(
  parameter int MAX_OUTPUT_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_wdata,
  input  jseu_pkg::jseu_qstat_t qstat,
  output logic                 push,
  output jseu_pkg::jseu_piece_t push_data
);
  import jseu_pkg::*;

  localparam int CW = $clog2(MAX_OUTPUT_BYTES + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [LW-1:0] MAX_LIM = LW'(MAX_OUTPUT_BYTES);

  logic [LIMIT_W-1:0] output_limit;
  logic [7:0]         pend [3];
  logic [1:0]         pcount, pcount_next;
  logic [2:0]         seqlen, seqlen_next;
  logic               rejected, rejected_next;
  logic [LW-1:0]      emitted, emitted_next;

  logic               accept;
  logic               pend_we;
  logic [1:0]         pend_idx;
  logic [2:0]         len;
  logic [PIECE_MAX-1:0][7:0] piece;
  logic [7:0]         esc;
  logic [LW-1:0]      lim;
  logic [LW-1:0]      room;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lim  = (LW'(output_limit) > MAX_LIM) ? MAX_LIM : LW'(output_limit);
    room = (emitted <= lim) ? (lim - emitted) : '0;
  end

  always_comb begin
    pcount_next   = pcount;
    seqlen_next   = seqlen;
    rejected_next = rejected;
    emitted_next  = emitted;
    pend_we       = 1'b0;
    pend_idx      = pcount;
    len           = 3'd0;
    piece         = '0;
    esc           = short_escape(in_byte);
    if (!rejected) begin
      if (seqlen != 3'd0) begin
        if ((in_byte & CONT_MASK) != CONT_TAG ||
            (pcount == 2'd1 && !second_byte_ok(pend[0], in_byte))) begin
          rejected_next = 1'b1;
        end else if ({1'b0, pcount} + 3'd1 >= seqlen) begin
          for (int i = 0; i < 4; i++) begin
            piece[i] = (i < int'(pcount)) ? pend[i[1:0]] : in_byte;
          end
          len         = {1'b0, pcount} + 3'd1;
          seqlen_next = 3'd0;
          pcount_next = 2'd0;
        end else begin
          pend_we     = 1'b1;
          pcount_next = pcount + 2'd1;
        end
      end else if (in_byte[7]) begin
        if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) seqlen_next = 3'd2;
        else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI) seqlen_next = 3'd3;
        else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) seqlen_next = 3'd4;
        else rejected_next = 1'b1;
        if (!rejected_next) begin
          pend_we     = 1'b1;
          pend_idx    = 2'd0;
          pcount_next = 2'd1;
        end
      end else if (esc != 8'h00) begin
        piece[0] = CH_BSLASH;
        piece[1] = esc;
        len      = 3'd2;
      end else if (in_byte < 8'h20) begin
        piece[0] = CH_BSLASH;
        piece[1] = CH_U;
        piece[2] = CH_ZERO;
        piece[3] = CH_ZERO;
        piece[4] = hex_digit(in_byte[7:4]);
        piece[5] = hex_digit(in_byte[3:0]);
        len      = 3'd6;
      end else begin
        piece[0] = in_byte;
        len      = 3'd1;
      end

      if (!rejected_next && len != 3'd0) begin
        if (LW'(len) > room) begin
          rejected_next = 1'b1;
          len           = 3'd0;
        end else begin
          emitted_next = emitted + LW'(len);
        end
      end
      if (!rejected_next && in_last && seqlen_next != 3'd0) rejected_next = 1'b1;
      if (rejected_next) len = 3'd0;
    end

    push_data.bytes = piece;
    push_data.len   = len;
    push_data.last  = in_last;
    push_data.rej   = rejected_next;
    push            = accept && (len != 3'd0 || in_last);

    if (in_last) begin
      pcount_next   = 2'd0;
      seqlen_next   = 3'd0;
      rejected_next = 1'b0;
      emitted_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= 13'd512;
      pcount       <= 2'd0;
      seqlen       <= 3'd0;
      rejected     <= 1'b0;
      emitted      <= '0;
    end else begin
      if (cfg_we) output_limit <= cfg_wdata;
      if (accept) begin
        pcount   <= pcount_next;
        seqlen   <= seqlen_next;
        rejected <= rejected_next;
        emitted  <= emitted_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pend_we) pend[pend_idx] <= in_byte;
  end

  `JSEU_ASSERT_NOW(a_idle_seq_empty, seqlen == 3'd0, pcount == 2'd0, "open count without sequence")
  `JSEU_ASSERT_NOW(a_seq_count_range, seqlen != 3'd0, pcount != 2'd0 && 3'(pcount) < seqlen, "held count out of range")
  `JSEU_ASSERT_NOW(a_push_has_room, push, !qstat.full, "push into full queue")

endmodule

// File: design/jseu_queue.sv
module jseu_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  jseu_pkg::jseu_piece_t push_data,
  input  logic                  pop,
  output jseu_pkg::jseu_piece_t head,
  output jseu_pkg::jseu_qstat_t qstat
);
  import jseu_pkg::*;

  jseu_piece_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + QPTR_W'(1);
    return r;
  endfunction

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// File: design/jseu_back.sv
`include "json_string_escaper_utf8_check_unit_defines.svh"
module jseu_back (
  input  logic                  clk,
  input  logic                  rst,
  input  jseu_pkg::jseu_piece_t head,
  input  jseu_pkg::jseu_qstat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_has_byte,
  output logic                  out_run_last,
  output logic                  out_end,
  output logic                  out_rejected
);
  import jseu_pkg::*;

  logic [2:0] pos;
  logic       load;
  logic       take;
  logic       cur_final;
  logic       has;

  assign has       = (head.len != 3'd0);
  assign cur_final = !has || (pos == head.len - 3'd1);
  assign load      = !out_valid || out_ready;
  assign take      = load && !qstat.empty;
  assign pop       = take && cur_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 3'd0;
    end else begin
      if (take) begin
        out_valid    <= 1'b1;
        out_byte     <= has ? head.bytes[pos] : 8'h00;
        out_has_byte <= has;
        out_run_last <= cur_final;
        out_end      <= cur_final && head.last;
        out_rejected <= !has && head.rej;
        pos          <= cur_final ? 3'd0 : pos + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `JSEU_ASSERT_NOW(a_pos_in_piece, !qstat.empty && has, pos < head.len, "position past piece")
  `JSEU_ASSERT_NOW(a_status_closes, out_valid && !out_has_byte, out_run_last && out_end, "status result not final")
  `JSEU_ASSERT_NEXT(a_pos_rewinds, pop, pos == 3'd0, "position kept after pop")

endmodule

// File: design/json_string_escaper_utf8_check_unit.sv
// JSON string escaper with strict UTF-8 checking. Bytes of a string enter one per
// transaction with in_last on the final byte; escaped bytes leave one per
// transaction, each with run-last and end marks, and a status-only result closes a
// string that was rejected or produced nothing on its final byte. The front
// classifies and checks one input byte per cycle while the queue has room; a
// two-entry piece queue feeds the output stage, which sends one byte per cycle
// while out_ready is high. Plain ASCII therefore flows at one byte per cycle when
// nothing stalls, through a queue slot and the output register; a two-byte escape
// sends 2 bytes, a \u00xx escape 6 and a UTF-8 sequence its length, so the input
// stalls once the queue fills and the sustained input rate is set by the output
// byte count. Held UTF-8 lead and continuation bytes push no piece. cfg_we writes
// output_limit (reset 512); values above MAX_OUTPUT_BYTES act as MAX_OUTPUT_BYTES.
module json_string_escaper_utf8_check_unit #(
  parameter int MAX_OUTPUT_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_run_last,
  output logic        out_end,
  output logic        out_rejected,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);
  import jseu_pkg::*;

  logic        push;
  logic        pop;
  jseu_piece_t push_data;
  jseu_piece_t head;
  jseu_qstat_t qstat;

  jseu_front #(
    .MAX_OUTPUT_BYTES(MAX_OUTPUT_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  jseu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  jseu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_run_last (out_run_last),
    .out_end      (out_end),
    .out_rejected (out_rejected)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_OUT     = 4096;
  localparam int RESET_LIMIT = 512;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       run_last;
    logic       fin;
    logic       rej;
  } esc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = 8'h00;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic out_has_byte;
  logic out_run_last;
  logic out_end;
  logic out_rejected;
  logic cfg_we = 1'b0;
  logic [jseu_pkg::LIMIT_W-1:0] cfg_wdata = '0;

  esc_result_t escaped_q[$];
  logic [7:0] text_q[$];

  logic [7:0] held_bytes [0:2];
  int held_count = 0;
  int utf8_len = 0;
  bit string_rejected = 1'b0;
  int bytes_out = 0;
  int limit_reg = RESET_LIMIT;

  int fault_count = 0;
  int burst_left = 0;
  bit tx_gaps = 1'b1;
  bit hold_req = 1'b0;
  int hold_cnt;
  int rx_mode = 0;
  int rx_tick = 0;
  logic [31:0] rx_pattern = '1;

  json_string_escaper_utf8_check_unit #(
    .MAX_OUTPUT_BYTES(MAX_OUT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_has_byte(out_has_byte),
    .out_run_last(out_run_last),
    .out_end(out_end),
    .out_rejected(out_rejected),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [7:0] nibble_to_hex(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + n;
    else c = 8'h61 + (n - 4'd10);
    return c;
  endfunction

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  task automatic predict_escape(input logic [7:0] b, input logic last);
    logic [7:0] piece [0:5];
    logic [7:0] esc;
    bit bad;
    int len;
    int i;
    int lim;
    int room;
    esc_result_t r;
    len = 0;
    if (!string_rejected) begin
      if (utf8_len != 0) begin
        bad = 1'b0;
        if (held_count == 1) begin
          case (held_bytes[0])
            8'he0: bad = (b < 8'ha0);
            8'hed: bad = (b >= 8'ha0);
            8'hf0: bad = (b < 8'h90);
            8'hf4: bad = (b > 8'h8f);
            default: bad = 1'b0;
          endcase
        end
        if (b[7:6] != 2'b10 || bad) begin
          string_rejected = 1'b1;
        end else if (held_count + 1 >= utf8_len) begin
          for (i = 0; i < held_count; i++) piece[i] = held_bytes[i];
          piece[held_count] = b;
          len = held_count + 1;
          utf8_len = 0;
          held_count = 0;
        end else begin
          held_bytes[held_count] = b;
          held_count++;
        end
      end else if (b >= 8'h80) begin
        if (b >= 8'hc2 && b <= 8'hdf) utf8_len = 2;
        else if (b >= 8'he0 && b <= 8'hef) utf8_len = 3;
        else if (b >= 8'hf0 && b <= 8'hf4) utf8_len = 4;
        else string_rejected = 1'b1;
        if (!string_rejected) begin
          held_bytes[0] = b;
          held_count = 1;
        end
      end else begin
        case (b)
          CH_QUOTE: esc = "\"";
          CH_BSL:   esc = "\\";
          CH_BS:    esc = "b";
          CH_FF:    esc = "f";
          CH_LF:    esc = "n";
          CH_CR:    esc = "r";
          CH_TAB:   esc = "t";
          default:  esc = 8'h00;
        endcase
        if (esc != 8'h00) begin
          piece[0] = "\\";
          piece[1] = esc;
          len = 2;
        end else if (b < 8'h20) begin
          piece[0] = "\\";
          piece[1] = "u";
          piece[2] = "0";
          piece[3] = "0";
          piece[4] = nibble_to_hex(b[7:4]);
          piece[5] = nibble_to_hex(b[3:0]);
          len = 6;
        end else begin
          piece[0] = b;
          len = 1;
        end
      end
      if (!string_rejected && len != 0) begin
        lim = (limit_reg > MAX_OUT) ? MAX_OUT : limit_reg;
        room = (bytes_out <= lim) ? lim - bytes_out : 0;
        if (len > room) begin
          string_rejected = 1'b1;
          len = 0;
        end else begin
          bytes_out += len;
        end
      end
      if (!string_rejected && last && utf8_len != 0) string_rejected = 1'b1;
      if (string_rejected) len = 0;
    end
    for (i = 0; i < len; i++) begin
      r = '{data: piece[i], has: 1'b1, run_last: (i == len - 1),
            fin: (i == len - 1) && last, rej: 1'b0};
      escaped_q.push_back(r);
    end
    if (last && len == 0) begin
      r = '{data: 8'h00, has: 1'b0, run_last: 1'b1, fin: 1'b1, rej: string_rejected};
      escaped_q.push_back(r);
    end
    if (last) begin
      held_count = 0;
      utf8_len = 0;
      string_rejected = 1'b0;
      bytes_out = 0;
    end
  endtask

  always @(posedge clk) begin
    esc_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (escaped_q.size() == 0) begin
        log_fault($sformatf("unexpected output: byte %02h has %0b run_last %0b end %0b rej %0b",
                            out_byte, out_has_byte, out_run_last, out_end, out_rejected));
      end else begin
        e = escaped_q.pop_front();
        if (out_byte !== e.data || out_has_byte !== e.has || out_run_last !== e.run_last ||
            out_end !== e.fin || out_rejected !== e.rej) begin
          log_fault($sformatf({"mismatch: expected byte %02h has %0b run_last %0b end %0b ",
                               "rej %0b, got byte %02h has %0b run_last %0b end %0b rej %0b"},
                              e.data, e.has, e.run_last, e.fin, e.rej, out_byte,
                              out_has_byte, out_run_last, out_end, out_rejected));
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
      end
      if (rx_tick == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_pattern = $urandom;
      end
      rx_tick = (rx_tick + 1) % 48;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: begin
          out_ready <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
        end
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = tx_gaps ? $urandom_range(0, 6) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    predict_escape(b, last);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (escaped_q.size() != 0);
  endtask

  task automatic set_limit(input int v);
    wait_drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[jseu_pkg::LIMIT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = v;
  endtask

  task automatic add_utf8_char();
    int n;
    logic [7:0] lead;
    logic [7:0] second;
    n = $urandom_range(2, 4);
    case (n)
      2: lead = 8'($urandom_range(8'hc2, 8'hdf));
      3: lead = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) == 0) ? 8'he0 : 8'hed)
                                            : 8'($urandom_range(8'he0, 8'hef));
      default: lead = ($urandom_range(0, 2) == 0)
                      ? (($urandom_range(0, 1) == 0) ? 8'hf0 : 8'hf4)
                      : 8'($urandom_range(8'hf0, 8'hf4));
    endcase
    case (lead)
      8'he0: second = 8'($urandom_range(8'ha0, 8'hbf));
      8'hed: second = 8'($urandom_range(8'h80, 8'h9f));
      8'hf0: second = 8'($urandom_range(8'h90, 8'hbf));
      8'hf4: second = 8'($urandom_range(8'h80, 8'h8f));
      default: second = 8'($urandom_range(8'h80, 8'hbf));
    endcase
    text_q.push_back(lead);
    text_q.push_back(second);
    repeat (n - 2) text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
  endtask

  task automatic add_noise();
    logic [7:0] lead;
    case ($urandom_range(0, 4))
      0: text_q.push_back(8'($urandom_range(0, 255)));
      1: text_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hc1))
                                                     : 8'($urandom_range(8'hf5, 8'hff)));
      2: begin
        text_q.push_back(8'($urandom_range(8'hc2, 8'hf4)));
        text_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h00, 8'h7f))
                                                    : 8'($urandom_range(8'hc0, 8'hff)));
      end
      3: begin
        case ($urandom_range(0, 3))
          0: begin
            lead = 8'he0;
            text_q.push_back(lead);
            text_q.push_back(8'($urandom_range(8'h80, 8'h9f)));
          end
          1: begin
            lead = 8'hed;
            text_q.push_back(lead);
            text_q.push_back(8'($urandom_range(8'ha0, 8'hbf)));
          end
          2: begin
            lead = 8'hf0;
            text_q.push_back(lead);
            text_q.push_back(8'($urandom_range(8'h80, 8'h8f)));
          end
          default: begin
            lead = 8'hf4;
            text_q.push_back(lead);
            text_q.push_back(8'($urandom_range(8'h90, 8'hbf)));
          end
        endcase
        text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
      end
      default: text_q.push_back(8'($urandom_range(8'hc2, 8'hf4)));
    endcase
  endtask

  task automatic add_piece();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      text_q.push_back(8'($urandom_range(8'h20, 8'h7f)));
    end else if (k < 55) begin
      case ($urandom_range(0, 6))
        0: text_q.push_back(CH_QUOTE);
        1: text_q.push_back(CH_BSL);
        2: text_q.push_back(CH_BS);
        3: text_q.push_back(CH_FF);
        4: text_q.push_back(CH_LF);
        5: text_q.push_back(CH_CR);
        default: text_q.push_back(CH_TAB);
      endcase
    end else if (k < 65) begin
      text_q.push_back(8'($urandom_range(8'h00, 8'h1f)));
    end else if (k < 90) begin
      add_utf8_char();
    end else begin
      add_noise();
    end
  endtask

  task automatic test_escapes();
    text_q = '{CH_QUOTE, CH_BSL, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB, 8'h00, 8'h1f, 8'h7f};
    send_text();
    wait_drain();
  endtask

  task automatic test_utf8_checks();
    text_q = '{8'hdf, 8'hbf, 8'he0, 8'ha0, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
    send_text();
    text_q = '{8'hed, 8'ha0};
    send_text();
    text_q = '{8'hc2};
    send_text();
    text_q = '{8'hff, 8'h41};
    send_text();
    wait_drain();
  endtask

  task automatic test_output_limit();
    set_limit(0);
    text_q = '{8'h41};
    send_text();
    text_q = '{8'h01};
    send_text();
    set_limit(1);
    text_q = '{8'h41, 8'h42};
    send_text();
    text_q = '{8'hc2, 8'h80};
    send_text();
    set_limit(6);
    text_q = '{8'h01};
    send_text();
    text_q = '{8'h01, 8'h41};
    send_text();
    set_limit(8191);
    text_q.delete();
    repeat (8) text_q.push_back(8'h1f);
    send_text();
    set_limit(MAX_OUT);
  endtask

  task automatic test_backpressure();
    wait_drain();
    tx_gaps = 1'b0;
    hold_req = 1'b1;
    text_q.delete();
    repeat (24) text_q.push_back(8'h01);
    send_text();
    tx_gaps = 1'b1;
    wait_drain();
  endtask

  task automatic test_random_strings(input int n_items, input int lo, input int hi);
    int sent;
    set_limit($urandom_range(lo, hi));
    sent = 0;
    while (sent < n_items) begin
      text_q.delete();
      repeat ($urandom_range(1, 6)) add_piece();
      send_text();
      sent += text_q.size();
    end
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_escapes();
    test_utf8_checks();
    test_output_limit();
    test_backpressure();
    test_random_strings(20, MAX_OUT, MAX_OUT);
    repeat (2) test_random_strings(10, 1, 48);
    wait_drain();
    repeat (20) @(posedge clk);
    if (fault_count == 0 && escaped_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
